/* hw/rtl/t4si_pkg.sv */
// Shared types, constants and lookup functions for the 4D toric code parity-check generator.
// Used by t4si_issue, t4si_pipe and toric4d_stabilizer_incidence; depends on nothing else.

package t4si_pkg;

   // Field and register widths.
   localparam int MAX_SIDE_DEFAULT = 16;
   localparam int SIDE_W           = 5;
   localparam int COORD_W          = 4;
   localparam int CELLS_W          = 17;
   localparam int ROW_W            = 18;
   localparam int COL_W            = 19;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 17;
   localparam int STEP_W           = 3;
   localparam int ORIENT_W         = 3;

   // Partial vertex index widths (coordinates below 16, sides at most 31).
   localparam int T1_W  = 10;
   localparam int T2_W  = 15;
   localparam int VTX_W = 19;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_SIDE_X     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SIDE_Y     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SIDE_Z     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SIDE_W     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CELL_COUNT = 3'd4;

   // Reset values of the registers.
   localparam logic [SIDE_W-1:0]  SIDE_RESET  = 5'd4;
   localparam logic [CELLS_W-1:0] CELLS_RESET = 17'd256;

   // Operation codes.
   localparam logic OP_X = 1'b0;
   localparam logic OP_Z = 1'b1;

   // Index of the sixth and final result of a stabilizer.
   localparam logic [STEP_W-1:0] LAST_STEP = 3'd5;

   // Face orientations: lower and upper axis of each.
   localparam logic [1:0] FACE_LO [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
   localparam logic [1:0] FACE_HI [6] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

   // The three axes that remain when one axis is dropped, in ascending order.
   localparam logic [1:0] CUBE_AXES [4][3] = '{
      '{2'd1, 2'd2, 2'd3},
      '{2'd0, 2'd2, 2'd3},
      '{2'd0, 2'd1, 2'd3},
      '{2'd0, 2'd1, 2'd2}
   };

   // Lattice geometry as seen by the datapath.
   typedef struct packed {
      logic [3:0][SIDE_W-1:0] side;
      logic [CELLS_W-1:0]     cell_count;
   } t4si_geom_type;

   // What one result of a stabilizer needs: face and the axis to step along.
   typedef struct packed {
      logic [ORIENT_W-1:0] orient;
      logic [1:0]          axis;
      logic                move;
      logic                up;
   } t4si_plan_type;

   // One result's worth of work handed from the issue stage to the pipeline.
   typedef struct packed {
      logic                    valid;
      logic                    bad;
      logic                    last;
      logic [1:0]              direction;
      t4si_plan_type           plan;
      logic [3:0][COORD_W-1:0] coord;
   } t4si_issue_type;

   // Face orientation of the axis pair {i, j}.
   function automatic logic [ORIENT_W-1:0] orient_of(input logic [1:0] i, input logic [1:0] j);
      logic [1:0]          lo;
      logic [1:0]          hi;
      logic [ORIENT_W-1:0] o;
      lo = (i < j) ? i : j;
      hi = (i < j) ? j : i;
      o  = '0;
      for (int k = 0; k < 6; k++) begin
         if (FACE_LO[k] == lo && FACE_HI[k] == hi) begin
            o = ORIENT_W'(k);
         end
      end
      return o;
   endfunction

   // Face and step for result number idx of a stabilizer.
   function automatic t4si_plan_type plan_of(input logic op, input logic [1:0] d,
                                             input logic [STEP_W-1:0] idx);
      t4si_plan_type p;
      logic [1:0]    a;
      logic [1:0]    b;
      logic [1:0]    e;
      logic [1:0]    j;
      a = CUBE_AXES[d][0];
      b = CUBE_AXES[d][1];
      e = CUBE_AXES[d][2];
      p = '0;
      if (op == OP_X) begin
         // Edge: each other axis in turn, at the vertex and one step down.
         case (idx)
            3'd0, 3'd1: j = a;
            3'd2, 3'd3: j = b;
            default:    j = e;
         endcase
         p.orient = orient_of(d, j);
         p.axis   = j;
         p.move   = idx[0];
         p.up     = 1'b0;
      end else begin
         // 3-cube: each face pair at the vertex and one step up the third axis.
         case (idx)
            3'd0: begin
               p.orient = orient_of(a, b);
               p.axis   = e;
               p.move   = 1'b0;
            end
            3'd1: begin
               p.orient = orient_of(a, b);
               p.axis   = e;
               p.move   = 1'b1;
            end
            3'd2: begin
               p.orient = orient_of(a, e);
               p.axis   = b;
               p.move   = 1'b0;
            end
            3'd3: begin
               p.orient = orient_of(a, e);
               p.axis   = b;
               p.move   = 1'b1;
            end
            3'd4: begin
               p.orient = orient_of(b, e);
               p.axis   = a;
               p.move   = 1'b0;
            end
            default: begin
               p.orient = orient_of(b, e);
               p.axis   = a;
               p.move   = 1'b1;
            end
         endcase
         p.up = 1'b1;
      end
      return p;
   endfunction

endpackage

/* hw/rtl/t4si_issue.sv */
// Issue stage: holds one stabilizer transaction, one result per cycle while advancing.
// Depends on t4si_pkg for the geometry, plan table and issue types.

module t4si_issue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  t4si_pkg::t4si_geom_type          geom,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_operation,
   input  logic [t4si_pkg::COORD_W-1:0]     req_coord_x,
   input  logic [t4si_pkg::COORD_W-1:0]     req_coord_y,
   input  logic [t4si_pkg::COORD_W-1:0]     req_coord_z,
   input  logic [t4si_pkg::COORD_W-1:0]     req_coord_w,
   input  logic [1:0]                       req_direction,
   output t4si_pkg::t4si_issue_type         issue
);

   logic                                       hold_valid_ff;
   logic                                       hold_valid_in;
   logic [t4si_pkg::STEP_W-1:0]                step_ff;
   logic [t4si_pkg::STEP_W-1:0]                step_in;
   logic                                       op_ff;
   logic [3:0][t4si_pkg::COORD_W-1:0]          coord_ff;
   logic [1:0]                                 dir_ff;
   logic                                       bad;
   logic                                       is_last;
   logic                                       fire;
   logic                                       take;

   // A coordinate at or beyond its side gives a single flagged result.
   always_comb begin
      bad = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if ({1'b0, coord_ff[k]} >= geom.side[k]) begin
            bad = 1'b1;
         end
      end
   end

   assign is_last   = bad || (step_ff == t4si_pkg::LAST_STEP);
   assign fire      = hold_valid_ff && advance;
   assign req_stall = !(!hold_valid_ff || (fire && is_last));
   assign take      = req_valid && !req_stall;

   // Sequencing of the held transaction.
   always_comb begin
      hold_valid_in = hold_valid_ff;
      step_in       = step_ff;
      if (take) begin
         hold_valid_in = 1'b1;
         step_in       = '0;
      end else if (fire && is_last) begin
         hold_valid_in = 1'b0;
      end else if (fire) begin
         step_in = step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         step_ff       <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         step_ff       <= step_in;
      end
   end

   // Transaction payload.
   always_ff @(posedge clock) begin
      if (take) begin
         op_ff       <= req_operation;
         coord_ff[0] <= req_coord_x;
         coord_ff[1] <= req_coord_y;
         coord_ff[2] <= req_coord_z;
         coord_ff[3] <= req_coord_w;
         dir_ff      <= req_direction;
      end
   end

   // The current result's work item.
   always_comb begin
      issue.valid     = hold_valid_ff;
      issue.bad       = bad;
      issue.last      = is_last;
      issue.direction = dir_ff;
      issue.plan      = t4si_pkg::plan_of(op_ff, dir_ff, step_ff);
      issue.coord     = coord_ff;
   end

   // A held transaction never counts past its sixth result.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> (step_ff <= t4si_pkg::LAST_STEP))
      else $error("issue step counter beyond the last result");

   // Once the final result is handed on, a new transaction starts at its first result.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      take |=> (hold_valid_ff && step_ff == '0))
      else $error("new transaction did not start at its first result");

   // An empty issue stage always accepts a transaction.
   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !hold_valid_ff |-> !req_stall)
      else $error("empty issue stage stalls its input");

endmodule

/* hw/rtl/t4si_pipe.sv */
// Five-stage index pipeline: lattice step, three multiply-add stages for the vertex index,
// and the row and column scaling into the output register. Depends on t4si_pkg.

module t4si_pipe (
   input  logic                             clock,
   input  logic                             reset,
   input  t4si_pkg::t4si_geom_type          geom,
   input  t4si_pkg::t4si_issue_type         issue,
   output logic                             advance,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [t4si_pkg::ROW_W-1:0]       rsp_row_index,
   output logic [t4si_pkg::COL_W-1:0]       rsp_column_index,
   output logic                             rsp_bad_input,
   output logic                             rsp_last
);

   typedef struct packed {
      logic                          bad;
      logic                          last;
      logic [1:0]                    direction;
      logic [t4si_pkg::ORIENT_W-1:0] orient;
   } tag_type;

   // Stage A: anchor and stepped coordinates.
   logic                                   a_valid_ff;
   tag_type                                a_tag_ff;
   logic [3:0][t4si_pkg::COORD_W-1:0]      a_anchor_ff;
   logic [3:0][t4si_pkg::SIDE_W-1:0]       a_moved_ff;
   logic [3:0][t4si_pkg::SIDE_W-1:0]       a_moved_in;
   tag_type                                a_tag_in;

   // Stage B: first partial index.
   logic                                   b_valid_ff;
   tag_type                                b_tag_ff;
   logic [t4si_pkg::T1_W-1:0]              b_anchor_ff;
   logic [t4si_pkg::T1_W-1:0]              b_moved_ff;
   logic [1:0][t4si_pkg::COORD_W-1:0]      b_anchor_lo_ff;
   logic [1:0][t4si_pkg::SIDE_W-1:0]       b_moved_lo_ff;

   // Stage C: second partial index.
   logic                                   c_valid_ff;
   tag_type                                c_tag_ff;
   logic [t4si_pkg::T2_W-1:0]              c_anchor_ff;
   logic [t4si_pkg::T2_W-1:0]              c_moved_ff;
   logic [t4si_pkg::COORD_W-1:0]           c_anchor_lo_ff;
   logic [t4si_pkg::SIDE_W-1:0]            c_moved_lo_ff;

   // Stage D: full vertex indexes.
   logic                                   d_valid_ff;
   tag_type                                d_tag_ff;
   logic [t4si_pkg::VTX_W-1:0]             d_anchor_ff;
   logic [t4si_pkg::VTX_W-1:0]             d_moved_ff;

   // Stage E: output register.
   logic                                   e_valid_ff;
   logic [t4si_pkg::ROW_W-1:0]             e_row_ff;
   logic [t4si_pkg::ROW_W-1:0]             e_row_in;
   logic [t4si_pkg::COL_W-1:0]             e_col_ff;
   logic [t4si_pkg::COL_W-1:0]             e_col_in;
   logic                                   e_bad_ff;
   logic                                   e_last_ff;

   logic [t4si_pkg::SIDE_W-1:0]            cur;
   logic [t4si_pkg::SIDE_W-1:0]            cur_up;
   logic [t4si_pkg::SIDE_W-1:0]            lim;

   // The whole pipeline moves together whenever the output register can take a result.
   assign advance = !e_valid_ff || !rsp_stall;

   // Step one axis by one with wrap-around.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         a_moved_in[k] = {1'b0, issue.coord[k]};
      end
      cur    = {1'b0, issue.coord[issue.plan.axis]};
      cur_up = cur + 5'd1;
      lim    = geom.side[issue.plan.axis];
      if (issue.plan.move) begin
         if (issue.plan.up) begin
            a_moved_in[issue.plan.axis] = (cur_up == lim) ? '0 : cur_up;
         end else begin
            a_moved_in[issue.plan.axis] = (cur == '0) ? lim - 5'd1 : cur - 5'd1;
         end
      end
      a_tag_in.bad       = issue.bad;
      a_tag_in.last      = issue.last;
      a_tag_in.direction = issue.direction;
      a_tag_in.orient    = issue.plan.orient;
   end

   // Valid bits of every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= issue.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
   end

   // Row and column scaling by the cell count; a bad transaction gives zeros.
   always_comb begin
      e_row_in = t4si_pkg::ROW_W'({1'b0, d_tag_ff.direction} * geom.cell_count + d_anchor_ff);
      e_col_in = t4si_pkg::COL_W'(d_tag_ff.orient * geom.cell_count + d_moved_ff);
      if (d_tag_ff.bad) begin
         e_row_in = '0;
         e_col_in = '0;
      end
   end

   // Payload of every stage.
   always_ff @(posedge clock) begin
      if (advance) begin
         a_tag_ff    <= a_tag_in;
         a_anchor_ff <= issue.coord;
         a_moved_ff  <= a_moved_in;

         b_tag_ff       <= a_tag_ff;
         b_anchor_ff    <= t4si_pkg::T1_W'(a_anchor_ff[3] * geom.side[2] + a_anchor_ff[2]);
         b_moved_ff     <= t4si_pkg::T1_W'(a_moved_ff[3] * geom.side[2] + a_moved_ff[2]);
         b_anchor_lo_ff <= a_anchor_ff[1:0];
         b_moved_lo_ff  <= a_moved_ff[1:0];

         c_tag_ff       <= b_tag_ff;
         c_anchor_ff    <= t4si_pkg::T2_W'(b_anchor_ff * geom.side[1] + b_anchor_lo_ff[1]);
         c_moved_ff     <= t4si_pkg::T2_W'(b_moved_ff * geom.side[1] + b_moved_lo_ff[1]);
         c_anchor_lo_ff <= b_anchor_lo_ff[0];
         c_moved_lo_ff  <= b_moved_lo_ff[0];

         d_tag_ff    <= c_tag_ff;
         d_anchor_ff <= t4si_pkg::VTX_W'(c_anchor_ff * geom.side[0] + c_anchor_lo_ff);
         d_moved_ff  <= t4si_pkg::VTX_W'(c_moved_ff * geom.side[0] + c_moved_lo_ff);

         e_row_ff  <= e_row_in;
         e_col_ff  <= e_col_in;
         e_bad_ff  <= d_tag_ff.bad;
         e_last_ff <= d_tag_ff.last;
      end
   end

   assign rsp_valid        = e_valid_ff;
   assign rsp_row_index    = e_row_ff;
   assign rsp_column_index = e_col_ff;
   assign rsp_bad_input    = e_bad_ff;
   assign rsp_last         = e_last_ff;

endmodule

/* hw/rtl/toric4d_stabilizer_incidence.sv */
// An accepted transaction passes the issue register and pipeline stages A to E; its results
// leave one per cycle while rsp_stall is low. A transaction gives six results (one for a
// flagged coordinate) on the single result channel that carries all six face columns.
// A new input is taken in the cycle its predecessor's final result enters the pipeline.
// Reset (synchronous) empties the pipeline and restores sides of 4 and a cell count of 256.
// Top level: configuration registers, issue stage and index pipeline; depends on t4si_pkg.

module toric4d_stabilizer_incidence #(
   parameter int MAX_SIDE = t4si_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [t4si_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [t4si_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [t4si_pkg::COORD_W-1:0]        req_coord_x,
   input  logic [t4si_pkg::COORD_W-1:0]        req_coord_y,
   input  logic [t4si_pkg::COORD_W-1:0]        req_coord_z,
   input  logic [t4si_pkg::COORD_W-1:0]        req_coord_w,
   input  logic [1:0]                          req_direction,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [t4si_pkg::ROW_W-1:0]          rsp_row_index,
   output logic [t4si_pkg::COL_W-1:0]          rsp_column_index,
   output logic                                rsp_bad_input,
   output logic                                rsp_last
);

   logic [3:0][t4si_pkg::SIDE_W-1:0]   side_ff;
   logic [t4si_pkg::CELLS_W-1:0]       cells_ff;
   t4si_pkg::t4si_geom_type            geom;
   t4si_pkg::t4si_issue_type           issue;
   logic                               advance;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff  <= {4{t4si_pkg::SIDE_RESET}};
         cells_ff <= t4si_pkg::CELLS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            t4si_pkg::REG_SIDE_X:     side_ff[0] <= csr_write_data[t4si_pkg::SIDE_W-1:0];
            t4si_pkg::REG_SIDE_Y:     side_ff[1] <= csr_write_data[t4si_pkg::SIDE_W-1:0];
            t4si_pkg::REG_SIDE_Z:     side_ff[2] <= csr_write_data[t4si_pkg::SIDE_W-1:0];
            t4si_pkg::REG_SIDE_W:     side_ff[3] <= csr_write_data[t4si_pkg::SIDE_W-1:0];
            t4si_pkg::REG_CELL_COUNT: cells_ff   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Sides above the maximum saturate to it.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         geom.side[k] = (int'(side_ff[k]) > MAX_SIDE) ? t4si_pkg::SIDE_W'(MAX_SIDE) : side_ff[k];
      end
      geom.cell_count = cells_ff;
   end

   t4si_issue u_issue (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .geom          (geom),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_coord_x   (req_coord_x),
      .req_coord_y   (req_coord_y),
      .req_coord_z   (req_coord_z),
      .req_coord_w   (req_coord_w),
      .req_direction (req_direction),
      .issue         (issue)
   );

   t4si_pipe u_pipe (
      .clock            (clock),
      .reset            (reset),
      .geom             (geom),
      .issue            (issue),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_index    (rsp_row_index),
      .rsp_column_index (rsp_column_index),
      .rsp_bad_input    (rsp_bad_input),
      .rsp_last         (rsp_last)
   );

   // A flagged transaction is a single result.
   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_input) |-> rsp_last)
      else $error("flagged result not marked as last");

   // A flagged result carries zero indexes.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_input) |-> (rsp_row_index == '0 && rsp_column_index == '0))
      else $error("flagged result carries non-zero indexes");

   // Results of one transaction follow each other without a gap.
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> rsp_valid)
      else $error("gap inside the results of one transaction");

endmodule
